// ===== hw/rtl/xtea_pkg.sv =====
`default_nettype none

package xtea_pkg;

  localparam int unsigned ROUNDS = 32;
  localparam int unsigned LATENCY = 2 * ROUNDS;

  localparam logic [31:0] DELTA = 32'h9E3779B9;
  localparam logic [63:0] SUM_DEC_WIDE = 64'(ROUNDS) * 64'(DELTA);
  localparam logic [31:0] SUM_DEC = SUM_DEC_WIDE[31:0];
  localparam logic [31:0] SUM_ENC = 32'h0000_0000;

  localparam logic [31:0] KEY0_RESET = 32'h0123_4567;
  localparam logic [31:0] KEY1_RESET = 32'h89AB_CDEF;
  localparam logic [31:0] KEY2_RESET = 32'hFEDC_BA98;
  localparam logic [31:0] KEY3_RESET = 32'h7654_3210;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef enum logic [1:0] {
    KEY_WORD0 = 2'd0,
    KEY_WORD1 = 2'd1,
    KEY_WORD2 = 2'd2,
    KEY_WORD3 = 2'd3
  } cfg_reg_t;

  typedef logic [3:0][31:0] key_t;

  typedef struct packed {
    logic        op;
    logic [31:0] block_first;
    logic [31:0] block_second;
  } req_t;

  typedef struct packed {
    logic [31:0] result_first;
    logic [31:0] result_second;
  } res_t;

  typedef struct packed {
    logic        op;
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
  } stage_t;

  function automatic logic [31:0] mix_word(input logic [31:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  function automatic logic [31:0] round_term(input logic [31:0] v, input logic [31:0] s,
                                             input logic [31:0] k);
    return mix_word(v) ^ (s + k);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/xtea_round.sv =====
`default_nettype none

module xtea_round (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire xtea_pkg::key_t  key,
  input  wire logic            in_valid,
  input  wire xtea_pkg::stage_t in_data,
  output logic                 out_valid,
  output xtea_pkg::stage_t     out_data
);

  logic             mid_valid;
  xtea_pkg::stage_t mid;
  xtea_pkg::stage_t mid_next;
  xtea_pkg::stage_t out_next;

  always_comb begin
    mid_next = in_data;
    if (in_data.op == xtea_pkg::OP_ENCRYPT) begin
      mid_next.v0  = in_data.v0 + xtea_pkg::round_term(in_data.v1, in_data.sum,
                                                       key[in_data.sum[1:0]]);
      mid_next.sum = in_data.sum + xtea_pkg::DELTA;
    end else begin
      mid_next.v1  = in_data.v1 - xtea_pkg::round_term(in_data.v0, in_data.sum,
                                                       key[in_data.sum[12:11]]);
      mid_next.sum = in_data.sum - xtea_pkg::DELTA;
    end
  end

  always_comb begin
    out_next = mid;
    if (mid.op == xtea_pkg::OP_ENCRYPT) begin
      out_next.v1 = mid.v1 + xtea_pkg::round_term(mid.v0, mid.sum, key[mid.sum[12:11]]);
    end else begin
      out_next.v0 = mid.v0 - xtea_pkg::round_term(mid.v1, mid.sum, key[mid.sum[1:0]]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    mid      <= mid_next;
    out_data <= out_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/xtea_block_encrypt_decrypt.sv =====
// Channel   Handshake                Payload
// request   start / busy             req   (op, block_first, block_second)
// result    done (one-cycle strobe)  res   (result_first, result_second)
// config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One request enters per cycle; busy stays low.
// Each result passes through one register stage per half-round after acceptance.
// Synchronous reset clears valid bits and restores the key words.
// No stalls: the receiver takes every result, so the pipeline always advances.
`default_nettype none

module xtea_block_encrypt_decrypt (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire xtea_pkg::req_t req,
  output logic               done,
  output xtea_pkg::res_t     res,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_data
);

  xtea_pkg::key_t   key;
  logic             valid_chain [0:xtea_pkg::ROUNDS];
  xtea_pkg::stage_t data_chain  [0:xtea_pkg::ROUNDS];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key[0] <= xtea_pkg::KEY0_RESET;
      key[1] <= xtea_pkg::KEY1_RESET;
      key[2] <= xtea_pkg::KEY2_RESET;
      key[3] <= xtea_pkg::KEY3_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (xtea_pkg::cfg_reg_t'(cfg_index))
        xtea_pkg::KEY_WORD0: key[0] <= cfg_data;
        xtea_pkg::KEY_WORD1: key[1] <= cfg_data;
        xtea_pkg::KEY_WORD2: key[2] <= cfg_data;
        xtea_pkg::KEY_WORD3: key[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign valid_chain[0] = start && !busy;
  assign data_chain[0]  = '{op:  req.op,
                            v0:  req.block_first,
                            v1:  req.block_second,
                            sum: (req.op == xtea_pkg::OP_DECRYPT) ? xtea_pkg::SUM_DEC
                                                                   : xtea_pkg::SUM_ENC};

  for (genvar r = 0; r < xtea_pkg::ROUNDS; r++) begin : g_round
    xtea_round u_round (
      .clk      (clk),
      .rst      (rst),
      .key      (key),
      .in_valid (valid_chain[r]),
      .in_data  (data_chain[r]),
      .out_valid(valid_chain[r+1]),
      .out_data (data_chain[r+1])
    );
  end

  assign done              = valid_chain[xtea_pkg::ROUNDS];
  assign res.result_first  = data_chain[xtea_pkg::ROUNDS].v0;
  assign res.result_second = data_chain[xtea_pkg::ROUNDS].v1;

`ifndef NO_ASSERTIONS
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, xtea_pkg::LATENCY))
    else $error("result strobe without a matching request");

  a_reset_drops_results: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

  a_key_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == xtea_pkg::KEY_WORD2) |=> key[2] == $past(cfg_data))
    else $error("key word write lost");
`endif

endmodule

`default_nettype wire
